// ===== design/scba_pkg.sv =====
`default_nettype none

package scba_pkg;

    // Pool geometry and size classes.
    localparam int NUM_PAGES  = 64;
    localparam int PAGE_BYTES = 4096;
    localparam int MIN_BLOCK  = 16;
    localparam int MAX_BLOCK  = 2048;

    localparam int ADDR_W   = 18;
    localparam int SIZE_W   = 16;
    localparam int USE_W    = 12;
    localparam int ST_W     = 3;
    localparam int TYPE_W   = 2;
    localparam int PAGE_LOG = $clog2(PAGE_BYTES);
    localparam int PAGE_W   = $clog2(NUM_PAGES);
    localparam int MIN_LOG  = $clog2(MIN_BLOCK);
    localparam int CLASS_N  = $clog2(MAX_BLOCK) - MIN_LOG + 1;
    localparam int CLASS_W  = $clog2(CLASS_N);
    localparam int SLOT_W   = ADDR_W - MIN_LOG;
    localparam int SLOTS    = 1 << SLOT_W;
    localparam int CNT_W    = PAGE_W + 1;
    localparam int OFF_W    = PAGE_LOG;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [ST_W-1:0] ST_NULL      = 3'd4;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] req_addr;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] block_addr;
        logic [USE_W-1:0]  usable_bytes;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FILL,
        S_POP
    } t_state;

    // Block size in bytes of a size class.
    function automatic logic [USE_W-1:0] cls_bytes(input logic [CLASS_W-1:0] cls);
        cls_bytes = USE_W'(MIN_BLOCK) << cls;
    endfunction

endpackage

`default_nettype wire

// ===== design/size_class_block_allocator.sv =====
// A free, a query or a refused allocate gives its result from the evaluate state, a pop from a
// non-empty list from the pop state; a refill writes one link per cycle, PAGE_BYTES / block - 2
// writes, and then hands out the top block of the new page.
// Throughput: one request at a time; busy stays high until the result strobe.
// The receiver cannot stall: o_done marks the result for exactly one cycle.
// Reset (synchronous, active low) empties all lists and returns every page to the pool.
`default_nettype none

module size_class_block_allocator
    import scba_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_rsp   r_rsp, n_rsp;
    logic   r_done, n_done;

    logic [ADDR_W-1:0]  r_heads [CLASS_N];
    logic [CNT_W-1:0]   r_pages_used, n_pages_used;
    logic [CLASS_W-1:0] r_cls, n_cls;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [OFF_W-1:0]   r_off, n_off;

    // Link memory, one entry per smallest-block slot of the pool.
    logic [ADDR_W-1:0]  r_link_mem [SLOTS];
    logic [ADDR_W-1:0]  r_link_rd;
    logic               link_we;
    logic [SLOT_W-1:0]  link_wa;
    logic [ADDR_W-1:0]  link_wd;

    // Class of each assigned page; pages are handed out in order, so the
    // count of used pages tells which entries are valid.
    logic [CLASS_W-1:0] r_pc_mem [NUM_PAGES];
    logic [CLASS_W-1:0] r_pc_rd;
    logic               pc_we;

    logic               head_we;
    logic [ADDR_W-1:0]  head_wd;

    // Decode of the held request.
    logic [CLASS_W-1:0] alloc_cls, eval_cls, cur_cls;
    logic [USE_W-1:0]   cur_bsize;
    logic [ADDR_W-1:0]  hd_rd, aligned;
    logic [PAGE_W-1:0]  req_page;
    logic               too_large, head_nz, exhausted, page_ok, hdr_blk, addr_null;
    logic               fill_top;
    logic [ADDR_W-1:0]  fill_prev;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Round the requested size up to its class.
    always_comb begin
        alloc_cls = CLASS_W'(CLASS_N - 1);
        for (int c = CLASS_N - 1; c >= 0; c--) begin
            if (r_req.req_size <= SIZE_W'(MIN_BLOCK << c)) begin
                alloc_cls = CLASS_W'(c);
            end
        end
    end

    assign too_large = (r_req.req_size > SIZE_W'(MAX_BLOCK));
    assign eval_cls  = (r_req.req_type == REQ_ALLOC) ? alloc_cls : r_pc_rd;
    assign cur_cls   = (r_state == S_EVAL) ? eval_cls : r_cls;
    assign cur_bsize = cls_bytes(cur_cls);
    assign hd_rd     = r_heads[cur_cls];
    assign head_nz   = (hd_rd != '0);
    assign exhausted = r_pages_used[CNT_W-1];
    assign req_page  = r_req.req_addr[ADDR_W-1:PAGE_LOG];
    assign page_ok   = ({1'b0, req_page} < r_pages_used);
    assign addr_null = (r_req.req_addr == '0);
    assign aligned   = r_req.req_addr & ~(ADDR_W'(cur_bsize) - ADDR_W'(1));
    assign hdr_blk   = (aligned[PAGE_LOG-1:0] == '0);

    // Refill walk: the block offset steps through the page by the block size.
    assign fill_top  = (({1'b0, r_off} + {1'b0, cur_bsize}) == (OFF_W + 1)'(PAGE_BYTES));
    assign fill_prev = (r_off == OFF_W'(cur_bsize)) ? '0 :
                       {r_page, r_off - OFF_W'(cur_bsize)};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_req.req_type == REQ_ALLOC && !too_large && head_nz) begin
                    n_state = S_POP;
                end else if (r_req.req_type == REQ_ALLOC && !too_large && !exhausted) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                if (fill_top) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result.
    always_comb begin
        n_req        = r_req;
        n_rsp        = r_rsp;
        n_done       = 1'b0;
        n_pages_used = r_pages_used;
        n_cls        = r_cls;
        n_page       = r_page;
        n_off        = r_off;
        head_we      = 1'b0;
        head_wd      = '0;
        link_we      = 1'b0;
        link_wa      = '0;
        link_wd      = '0;
        pc_we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                end
            end
            S_EVAL: begin
                n_cls  = eval_cls;
                n_done = 1'b1;
                n_rsp  = '{status: ST_OK, block_addr: '0, usable_bytes: '0};
                case (r_req.req_type)
                    REQ_ALLOC: begin
                        if (too_large) begin
                            n_rsp.status = ST_TOO_LARGE;
                        end else if (head_nz) begin
                            n_done = 1'b0;
                        end else if (exhausted) begin
                            n_rsp.status = ST_EXHAUSTED;
                        end else begin
                            n_done       = 1'b0;
                            pc_we        = 1'b1;
                            n_pages_used = r_pages_used + CNT_W'(1);
                            n_page       = r_pages_used[PAGE_W-1:0];
                            n_off        = OFF_W'(cur_bsize);
                        end
                    end
                    REQ_FREE: begin
                        if (addr_null) begin
                            n_rsp.status = ST_NULL;
                        end else if (!page_ok || hdr_blk) begin
                            n_rsp.status = ST_INVALID;
                        end else begin
                            link_we = 1'b1;
                            link_wa = aligned[ADDR_W-1:MIN_LOG];
                            link_wd = hd_rd;
                            head_we = 1'b1;
                            head_wd = aligned;
                        end
                    end
                    REQ_QUERY: begin
                        if (addr_null) begin
                            n_rsp.status = ST_NULL;
                        end else if (page_ok) begin
                            n_rsp.usable_bytes = cur_bsize;
                        end
                    end
                    default: begin
                        n_rsp.status = ST_OK;
                    end
                endcase
            end
            S_FILL: begin
                if (fill_top) begin
                    // The top block is handed out at once; its link becomes the head.
                    head_we = 1'b1;
                    head_wd = fill_prev;
                    n_done  = 1'b1;
                    n_rsp   = '{status: ST_OK, block_addr: {r_page, r_off},
                                usable_bytes: cur_bsize};
                end else begin
                    link_we = 1'b1;
                    link_wa = {r_page, r_off[OFF_W-1:MIN_LOG]};
                    link_wd = fill_prev;
                    n_off   = r_off + OFF_W'(cur_bsize);
                end
            end
            S_POP: begin
                head_we = 1'b1;
                head_wd = r_link_rd;
                n_done  = 1'b1;
                n_rsp   = '{status: ST_OK, block_addr: hd_rd, usable_bytes: cur_bsize};
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_pages_used <= '0;
            for (int c = 0; c < CLASS_N; c++) begin
                r_heads[c] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_done       <= n_done;
            r_pages_used <= n_pages_used;
            if (head_we) begin
                r_heads[cur_cls] <= head_wd;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_cls  <= n_cls;
        r_page <= n_page;
        r_off  <= n_off;
    end

    // Link memory: the head of the current class is always being read.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        r_link_rd <= r_link_mem[hd_rd[ADDR_W-1:MIN_LOG]];
    end

    // Page class memory, read at the page of the incoming request.
    always_ff @(posedge i_clk) begin
        if (pc_we) begin
            r_pc_mem[r_pages_used[PAGE_W-1:0]] <= eval_cls;
        end
        r_pc_rd <= r_pc_mem[i_req.req_addr[ADDR_W-1:PAGE_LOG]];
    end

endmodule

`default_nettype wire

// ===== design/scba_checker.sv =====
`default_nettype none

module scba_checker
    import scba_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  start,
    input wire  busy,
    input t_req i_req,
    input wire  o_done,
    input t_rsp o_rsp
);

    // A result never shows while a request is still in work.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transfer makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A request that fails returns no address.
    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> (o_rsp.block_addr == '0))
        else $error("address returned with a failure status");

    // A returned block is aligned and has a size.
    a_addr_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.block_addr != '0) |->
        (o_rsp.usable_bytes != '0 && o_rsp.block_addr[MIN_LOG-1:0] == '0))
        else $error("returned block misaligned or without size");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire
